FILE: design/dvdhl_pkg.sv
// Shared types and constants for the DVD subpicture highlight recolor block.
// No dependencies; imported by dvdhl_shade and the top level.
`default_nettype none

package dvdhl_pkg;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int NIBBLE_W    = 4;
	localparam int RGB_W       = 24;
	localparam int RGBA_W      = 32;
	localparam int CODE_W      = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HIGHLIGHT_ENABLE = 3'd0,
		REG_BOX_LEFT         = 3'd1,
		REG_BOX_RIGHT        = 3'd2,
		REG_BOX_TOP          = 3'd3,
		REG_BOX_BOTTOM       = 3'd4,
		REG_COLOR_SELECT     = 3'd5,
		REG_CONTRAST_SELECT  = 3'd6
	} cfg_reg_t;

	localparam logic ACT_PALETTE = 1'b0;
	localparam logic ACT_PIXEL   = 1'b1;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] color_select;
		logic [CFG_DATA_W-1:0] contrast_select;
	} hl_sel_t;

	typedef struct packed {
		logic [RGBA_W-1:0] rgba;
		logic              recolored;
	} hl_res_t;

endpackage

`default_nettype wire

FILE: design/dvdhl_shade.sv
// Per-pixel highlight decision: code to palette index / contrast, premultiply.
// Depends on dvdhl_pkg; palette storage lives in the top level.
`default_nettype none

module dvdhl_shade import dvdhl_pkg::*; (
	input  wire logic                in_box,
	input  wire logic [CODE_W-1:0]   code,
	input  wire logic [RGBA_W-1:0]   orig,
	input  wire hl_sel_t             sel,
	output logic      [NIBBLE_W-1:0] pal_idx,
	input  wire logic [RGB_W-1:0]    pal_rgb,
	output hl_res_t                  res
);

	localparam logic [15:0] ROUND_BIAS  = 16'd128;
	localparam logic [23:0] UNITY_SCALE = 24'd257;
	localparam int          ALPHA_SHIFT = 4;

	// ((v*a + 128) * 257) >> 16, exact 8-bit rounding of v*a/255
	function automatic logic [7:0] premul(input logic [7:0] v, input logic [7:0] a);
		logic [15:0] p;
		logic [15:0] q;
		logic [23:0] r;
		p = 16'(v) * 16'(a);
		q = p + ROUND_BIAS;
		r = 24'(q) * UNITY_SCALE;
		return r[23:16];
	endfunction

	logic [NIBBLE_W-1:0] contrast;
	logic [7:0]          alpha;
	logic                bad_code;

	always_comb begin
		case (code[1:0])
			2'd0: begin
				pal_idx  = sel.color_select[3:0];
				contrast = sel.contrast_select[3:0];
			end
			2'd1: begin
				pal_idx  = sel.color_select[7:4];
				contrast = sel.contrast_select[7:4];
			end
			2'd2: begin
				pal_idx  = sel.color_select[11:8];
				contrast = sel.contrast_select[11:8];
			end
			default: begin
				pal_idx  = sel.color_select[15:12];
				contrast = sel.contrast_select[15:12];
			end
		endcase
	end

	assign alpha    = {contrast, {ALPHA_SHIFT{1'b0}}};
	assign bad_code = |code[CODE_W-1:2];

	always_comb begin
		if (!in_box) begin
			res.rgba      = orig;
			res.recolored = 1'b0;
		end else if (bad_code) begin
			res.rgba      = '0;
			res.recolored = 1'b1;
		end else begin
			res.rgba      = {alpha, premul(pal_rgb[23:16], alpha),
				premul(pal_rgb[15:8], alpha), premul(pal_rgb[7:0], alpha)};
			res.recolored = 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: design/dvd_subpicture_highlight_recolor_core.sv
// DVD subpicture highlight recolor, top level.
// Input channel (in_valid/in_ready) carries either a palette load (action 0)
// or a pixel (action 1). Each pixel yields one transfer on the output channel
// (out_valid/out_ready); palette loads yield nothing.
// Pipeline: input register, then the box test, code decode and three 8x8
// premultiply products feed the output register. A pixel moves on from the input
// register to the output register unless the output register is stalled;
// one item per cycle is sustained while out_ready stays high.
// A palette load takes effect for every pixel that follows it in the stream.
// When the receiver stalls with a pixel held in the output register, a pixel
// in the input register waits and in_ready drops; palette loads still drain.
// Configuration (cfg_we/cfg_index/cfg_wdata) is written while idle; indexes
// beyond the register list are ignored.
// Reset clears the configuration registers and the pipeline valids; palette
// contents are undefined until loaded.
`default_nettype none

module dvd_subpicture_highlight_recolor_core import dvdhl_pkg::*; #(
	parameter int COORD_BITS      = 10,
	parameter int PALETTE_ENTRIES = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]             cfg_index,
	input  wire logic [CFG_DATA_W-1:0]              cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               action,
	input  wire logic [$clog2(PALETTE_ENTRIES)-1:0] entry_number,
	input  wire logic [RGB_W-1:0]                   entry_rgb,
	input  wire logic [COORD_BITS-1:0]              pixel_x,
	input  wire logic [COORD_BITS-1:0]              pixel_y,
	input  wire logic [CODE_W-1:0]                  pixel_code,
	input  wire logic [RGBA_W-1:0]                  original_rgba,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [RGBA_W-1:0]                  out_rgba,
	output logic                                    recolored
);

	localparam int ENTRY_W = $clog2(PALETTE_ENTRIES);

	// configuration
	logic                  hl_en_q;
	logic [COORD_BITS-1:0] left_q, right_q, top_q, bottom_q;
	hl_sel_t               sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_en_q  <= 1'b0;
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
			sel_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HIGHLIGHT_ENABLE: hl_en_q               <= cfg_wdata[0];
				REG_BOX_LEFT:         left_q                <= cfg_wdata[COORD_BITS-1:0];
				REG_BOX_RIGHT:        right_q               <= cfg_wdata[COORD_BITS-1:0];
				REG_BOX_TOP:          top_q                 <= cfg_wdata[COORD_BITS-1:0];
				REG_BOX_BOTTOM:       bottom_q              <= cfg_wdata[COORD_BITS-1:0];
				REG_COLOR_SELECT:     sel_q.color_select    <= cfg_wdata;
				REG_CONTRAST_SELECT:  sel_q.contrast_select <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input stage
	logic                  valid_s1;
	logic                  action_s1;
	logic [ENTRY_W-1:0]    entry_s1;
	logic [RGB_W-1:0]      rgb_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic [CODE_W-1:0]     code_s1;
	logic [RGBA_W-1:0]     orig_s1;

	logic                  valid_s2;
	hl_res_t               res_s2;

	logic stall, load_s1, adv_s2;

	// only a pixel needs the output register; palette loads never stall
	assign stall    = valid_s1 && (action_s1 == ACT_PIXEL) && valid_s2 && !out_ready;
	assign in_ready = !stall;
	assign load_s1  = in_valid && in_ready;
	assign adv_s2   = valid_s1 && (action_s1 == ACT_PIXEL) && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= stall || load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			action_s1 <= action;
			entry_s1  <= entry_number;
			rgb_s1    <= entry_rgb;
			x_s1      <= pixel_x;
			y_s1      <= pixel_y;
			code_s1   <= pixel_code;
			orig_s1   <= original_rgba;
		end
	end

	// palette
	logic [RGB_W-1:0]    palette_q [PALETTE_ENTRIES];
	logic [NIBBLE_W-1:0] pal_idx;
	logic [RGB_W-1:0]    pal_rgb;

	always_ff @(posedge clk) begin
		if (valid_s1 && (action_s1 == ACT_PALETTE)) begin
			palette_q[entry_s1] <= rgb_s1;
		end
	end

	assign pal_rgb = palette_q[pal_idx[ENTRY_W-1:0]];

	logic    in_box;
	hl_res_t res;

	assign in_box = hl_en_q && (x_s1 >= left_q) && (x_s1 <= right_q)
		&& (y_s1 >= top_q) && (y_s1 <= bottom_q);

	dvdhl_shade u_shade (
		.in_box  (in_box),
		.code    (code_s1),
		.orig    (orig_s1),
		.sel     (sel_q),
		.pal_idx (pal_idx),
		.pal_rgb (pal_rgb),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_rgba  = res_s2.rgba;
	assign recolored = res_s2.recolored;

`ifndef SYNTHESIS
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && valid_s1))
		else $error("in_ready low without an output stall");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (valid_s1 && action_s1 == ACT_PIXEL))
		else $error("stalled pixel lost from input stage");

	a_alpha_low_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && recolored) |-> (out_rgba[27:24] == 4'd0))
		else $error("recolored alpha not a multiple of sixteen");

	a_no_recolor_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hl_en_q) |-> !recolored)
		else $error("recolored pixel with highlight disabled");
`endif

endmodule

`default_nettype wire
